@@ sv/assert_macros.svh @@
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication, disabled while reset is high
`define ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, pre, post, msg) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error(msg);

`endif

@@ sv/hcsd_pkg.sv @@
package hcsd_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned NUM_WORDS = 16;
   localparam int unsigned NUM_DOUBLE_ROUNDS = 10;
   // each quarter round is split over two cells: two add-xor-rotate steps per cell
   localparam int unsigned CELLS_PER_DOUBLE = 4;
   localparam int unsigned NUM_CELLS = NUM_DOUBLE_ROUNDS * CELLS_PER_DOUBLE;

   // rotation amounts of the first and second half of a quarter round
   localparam int unsigned ROT_FIRST_A = 16;
   localparam int unsigned ROT_FIRST_B = 12;
   localparam int unsigned ROT_SECOND_A = 8;
   localparam int unsigned ROT_SECOND_B = 7;

   // chacha constants, state words 0 to 3
   localparam logic [WORD_W-1:0] SIGMA_0 = 32'h6170_7865;
   localparam logic [WORD_W-1:0] SIGMA_1 = 32'h3320_646e;
   localparam logic [WORD_W-1:0] SIGMA_2 = 32'h7962_2d32;
   localparam logic [WORD_W-1:0] SIGMA_3 = 32'h6b20_6574;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [NUM_WORDS-1:0][WORD_W-1:0] state_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_KEY_WORDS_0_1 = 2'd0,
      CSR_KEY_WORDS_2_3 = 2'd1,
      CSR_KEY_WORDS_4_5 = 2'd2,
      CSR_KEY_WORDS_6_7 = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [63:0] nonce_words_2_3;
      logic [63:0] nonce_words_0_1;
   } req_payload_type;

   typedef struct packed {
      logic [63:0] subkey_words_6_7;
      logic [63:0] subkey_words_4_5;
      logic [63:0] subkey_words_2_3;
      logic [63:0] subkey_words_0_1;
   } rsp_payload_type;

   function automatic word_type rotl(input word_type x, input int unsigned n);
      rotl = (x << n) | (x >> (WORD_W - n));
   endfunction

endpackage

@@ sv/hchacha20_subkey_derivation.sv @@
// hchacha20 subkey derivation engine
// csr_*: write channel for the 256-bit key, four 64-bit registers by index
//   (key words 0/1, 2/3, 4/5, 6/7, lower word in bits 31:0); csr_ready is
//   always high. Write the key only while no item is in flight.
// req_*: one nonce item (nonce words 0..3) per accepted handshake.
// rsp_*: one subkey item (state words 0..3 and 12..15) per nonce, in order.
// The rounds run through a chain of 40 cells, each doing half of the four
// parallel quarter rounds of one column or diagonal round and holding the
// 16-word state in a register; the last cell is the output register.
// Throughput is one item per cycle while rsp_ready stays high.
// When the receiver stalls with a result waiting, the whole chain holds and
// req_ready drops in the same cycle; items already in the chain are kept.
// Reset clears all stage valids and the key registers; the block takes
// items in the first cycle after reset.
module hchacha20_subkey_derivation (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  hcsd_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output hcsd_pkg::rsp_payload_type rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  hcsd_pkg::csr_index_type   csr_index,
   input  logic [63:0]               csr_data
);
   import hcsd_pkg::*;

   logic [63:0] key_0_1_ff;
   logic [63:0] key_2_3_ff;
   logic [63:0] key_4_5_ff;
   logic [63:0] key_6_7_ff;

   logic                      chain_en;
   state_type                 load_state;
   logic      [NUM_CELLS:0]   valid_link;
   state_type [NUM_CELLS:0]   state_link;

   // key registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_0_1_ff <= '0;
         key_2_3_ff <= '0;
         key_4_5_ff <= '0;
         key_6_7_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_KEY_WORDS_0_1: key_0_1_ff <= csr_data;
            CSR_KEY_WORDS_2_3: key_2_3_ff <= csr_data;
            CSR_KEY_WORDS_4_5: key_4_5_ff <= csr_data;
            CSR_KEY_WORDS_6_7: key_6_7_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // chain advances unless a finished result is held
   assign chain_en  = !valid_link[NUM_CELLS] || rsp_ready;
   assign req_ready = chain_en;

   // initial state: constants, key, nonce
   always_comb begin
      load_state[0]  = SIGMA_0;
      load_state[1]  = SIGMA_1;
      load_state[2]  = SIGMA_2;
      load_state[3]  = SIGMA_3;
      load_state[4]  = key_0_1_ff[31:0];
      load_state[5]  = key_0_1_ff[63:32];
      load_state[6]  = key_2_3_ff[31:0];
      load_state[7]  = key_2_3_ff[63:32];
      load_state[8]  = key_4_5_ff[31:0];
      load_state[9]  = key_4_5_ff[63:32];
      load_state[10] = key_6_7_ff[31:0];
      load_state[11] = key_6_7_ff[63:32];
      load_state[12] = req_data.nonce_words_0_1[31:0];
      load_state[13] = req_data.nonce_words_0_1[63:32];
      load_state[14] = req_data.nonce_words_2_3[31:0];
      load_state[15] = req_data.nonce_words_2_3[63:32];
   end

   assign valid_link[0] = req_valid;
   assign state_link[0] = load_state;

   // round cells: column first half, column second half, diagonal halves
   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      localparam bit          IS_DIAG   = ((k % CELLS_PER_DOUBLE) >= 2);
      localparam bit          IS_SECOND = ((k % 2) == 1);
      localparam int unsigned RA = IS_SECOND ? ROT_SECOND_A : ROT_FIRST_A;
      localparam int unsigned RB = IS_SECOND ? ROT_SECOND_B : ROT_FIRST_B;

      hcsd_cell #(
         .DIAG  (IS_DIAG),
         .ROT_A (RA),
         .ROT_B (RB)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (chain_en),
         .in_valid  (valid_link[k]),
         .in_state  (state_link[k]),
         .out_valid (valid_link[k+1]),
         .out_state (state_link[k+1])
      );
   end

   // result from the last cell
   assign rsp_valid = valid_link[NUM_CELLS];
   assign rsp_data.subkey_words_0_1 = {state_link[NUM_CELLS][1],  state_link[NUM_CELLS][0]};
   assign rsp_data.subkey_words_2_3 = {state_link[NUM_CELLS][3],  state_link[NUM_CELLS][2]};
   assign rsp_data.subkey_words_4_5 = {state_link[NUM_CELLS][13], state_link[NUM_CELLS][12]};
   assign rsp_data.subkey_words_6_7 = {state_link[NUM_CELLS][15], state_link[NUM_CELLS][14]};

endmodule

@@ sv/hcsd_cell.sv @@
module hcsd_cell #(
   parameter bit          DIAG  = 1'b0,
   parameter int unsigned ROT_A = hcsd_pkg::ROT_FIRST_A,
   parameter int unsigned ROT_B = hcsd_pkg::ROT_FIRST_B
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  hcsd_pkg::state_type in_state,
   output logic                out_valid,
   output hcsd_pkg::state_type out_state
);
   import hcsd_pkg::*;

   logic      valid_ff;
   state_type state_ff;
   state_type state_in;

   // half of four parallel quarter rounds: column or diagonal lanes
   always_comb begin
      word_type    a;
      word_type    b;
      word_type    c;
      word_type    d;
      logic [1:0]  ia;
      logic [1:0]  ib;
      logic [1:0]  ic;
      logic [1:0]  id;
      state_in = in_state;
      for (int lane = 0; lane < 4; lane++) begin
         ia = 2'(lane);
         ib = 2'(lane + (DIAG ? 1 : 0));
         ic = 2'(lane + (DIAG ? 2 : 0));
         id = 2'(lane + (DIAG ? 3 : 0));
         a = in_state[{2'd0, ia}];
         b = in_state[{2'd1, ib}];
         c = in_state[{2'd2, ic}];
         d = in_state[{2'd3, id}];
         a = a + b;
         d = rotl(d ^ a, ROT_A);
         c = c + d;
         b = rotl(b ^ c, ROT_B);
         state_in[{2'd0, ia}]  = a;
         state_in[{2'd1, ib}]  = b;
         state_in[{2'd2, ic}]  = c;
         state_in[{2'd3, id}]  = d;
      end
   end

   // stage register, moves with the whole chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         state_ff <= state_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_state = state_ff;

endmodule

@@ sv/hcsd_checker.sv @@
`include "assert_macros.svh"

module hcsd_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input hcsd_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input hcsd_pkg::rsp_payload_type rsp_data,
   input logic                      csr_valid,
   input logic                      csr_ready
);
   import hcsd_pkg::*;

   // a stalled result holds its value
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled result changed")

   // input side stalls exactly when a result is held
   `ASSERT_IMPL(a_req_ready, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready), "req_ready does not follow output stall")

   // a waiting nonce item holds its value
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data), "waiting nonce item changed")

   // key writes are never refused
   `ASSERT_IMPL(a_csr_ready, clock, reset, csr_valid, csr_ready, "key write refused")

   // no result right after reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "result valid after reset")

endmodule

bind hchacha20_subkey_derivation hcsd_checker u_hcsd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

@@ dv/tb.sv @@
module tb;
   import hcsd_pkg::*;

   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned CHUNK_ITEMS = 117;
   localparam int unsigned NUM_CHUNKS = 14;
   localparam int unsigned SETTLE_CYCLES = 60;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_KEY_WORDS_0_1;
   logic [63:0] csr_data = '0;

   // key as the block should hold it
   logic [63:0] key_model [0:3] = '{default: '0};

   rsp_payload_type subkey_queue [$];

   int unsigned req_idle_pct = 18;
   int unsigned rsp_idle_pct = 55;
   int unsigned hold_token = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;
   int unsigned stall_cycles = 0;
   int unsigned mismatch_count = 0;
   int unsigned nonces_sent = 0;
   int unsigned subkeys_checked = 0;
   int unsigned key_settings = 0;

   hchacha20_subkey_derivation dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   always #2 clock = ~clock;

   // rotate a 32-bit word left
   function automatic logic [31:0] rot_left(input logic [31:0] x, input int unsigned n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // one quarter round on words a, b, c, d, returned as {a, b, c, d}
   function automatic logic [127:0] quarter_mix(input logic [31:0] a, input logic [31:0] b,
                                                input logic [31:0] c, input logic [31:0] d);
      a = a + b; d = rot_left(d ^ a, 16);
      c = c + d; b = rot_left(b ^ c, 12);
      a = a + b; d = rot_left(d ^ a, 8);
      c = c + d; b = rot_left(b ^ c, 7);
      return {a, b, c, d};
   endfunction

   // subkey for one nonce under the current key
   function automatic rsp_payload_type derive_subkey(input req_payload_type n);
      logic [31:0] st [0:15];
      rsp_payload_type sk;
      st[0] = 32'h6170_7865;
      st[1] = 32'h3320_646e;
      st[2] = 32'h7962_2d32;
      st[3] = 32'h6b20_6574;
      for (int i = 0; i < 4; i++) begin
         st[4 + 2*i] = key_model[i][31:0];
         st[5 + 2*i] = key_model[i][63:32];
      end
      st[12] = n.nonce_words_0_1[31:0];
      st[13] = n.nonce_words_0_1[63:32];
      st[14] = n.nonce_words_2_3[31:0];
      st[15] = n.nonce_words_2_3[63:32];
      for (int r = 0; r < 10; r++) begin
         // column round
         {st[0], st[4], st[8],  st[12]} = quarter_mix(st[0], st[4], st[8],  st[12]);
         {st[1], st[5], st[9],  st[13]} = quarter_mix(st[1], st[5], st[9],  st[13]);
         {st[2], st[6], st[10], st[14]} = quarter_mix(st[2], st[6], st[10], st[14]);
         {st[3], st[7], st[11], st[15]} = quarter_mix(st[3], st[7], st[11], st[15]);
         // diagonal round
         {st[0], st[5], st[10], st[15]} = quarter_mix(st[0], st[5], st[10], st[15]);
         {st[1], st[6], st[11], st[12]} = quarter_mix(st[1], st[6], st[11], st[12]);
         {st[2], st[7], st[8],  st[13]} = quarter_mix(st[2], st[7], st[8],  st[13]);
         {st[3], st[4], st[9],  st[14]} = quarter_mix(st[3], st[4], st[9],  st[14]);
      end
      sk.subkey_words_0_1 = {st[1], st[0]};
      sk.subkey_words_2_3 = {st[3], st[2]};
      sk.subkey_words_4_5 = {st[13], st[12]};
      sk.subkey_words_6_7 = {st[15], st[14]};
      return sk;
   endfunction

   // random word, leaning toward carry and rotate corner values
   function automatic logic [31:0] rand_word();
      case ($urandom_range(15))
         0: return 32'h0000_0000;
         1: return 32'hffff_ffff;
         2: return 32'h1 << $urandom_range(31);
         3: return ~(32'h1 << $urandom_range(31));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [63:0] rand_dword();
      return {rand_word(), rand_word()};
   endfunction

   // offer one nonce item, idling first at random, and log its subkey on acceptance
   task automatic send_nonce(input logic [63:0] n01, input logic [63:0] n23);
      req_payload_type p;
      p.nonce_words_0_1 = n01;
      p.nonce_words_2_3 = n23;
      if (req_idle_pct > 0 && $urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      subkey_queue.push_back(derive_subkey(p));
      nonces_sent++;
   endtask

   task automatic write_key_reg(input csr_index_type idx, input logic [63:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      key_model[idx] = val;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key(input logic [63:0] k01, input logic [63:0] k23,
                           input logic [63:0] k45, input logic [63:0] k67);
      write_key_reg(CSR_KEY_WORDS_0_1, k01);
      write_key_reg(CSR_KEY_WORDS_2_3, k23);
      write_key_reg(CSR_KEY_WORDS_4_5, k45);
      write_key_reg(CSR_KEY_WORDS_6_7, k67);
      key_settings++;
   endtask

   // stop offering and wait for every outstanding subkey
   task automatic drain_pipeline();
      req_valid <= 1'b0;
      @(posedge clock);
      while (subkey_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // key straight out of reset must be all zero
   task automatic test_reset_key();
      send_nonce('0, '0);
      send_nonce('1, '1);
      drain_pipeline();
   endtask

   task automatic test_key_extremes();
      load_key('1, '1, '1, '1);
      send_nonce('0, '0);
      send_nonce('1, '1);
      send_nonce({16{4'h5}}, {16{4'ha}});
      send_nonce({16{4'ha}}, {16{4'h5}});
      drain_pipeline();
      load_key({16{4'h5}}, {16{4'ha}}, {16{4'h5}}, {16{4'ha}});
      send_nonce('1, '0);
      send_nonce('0, '1);
      drain_pipeline();
   endtask

   // top and bottom bits of every word, then a single register rewritten
   task automatic test_walking_bits();
      load_key({2{32'h8000_0000}}, {2{32'h0000_0001}}, {2{32'h8000_0001}}, {2{32'h7fff_fffe}});
      send_nonce({2{32'h8000_0000}}, {2{32'h0000_0001}});
      send_nonce({2{32'h7fff_ffff}}, {2{32'hffff_fffe}});
      drain_pipeline();
      write_key_reg(CSR_KEY_WORDS_4_5, 64'h0000_0001_0000_0000);
      key_settings++;
      send_nonce(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000);
      send_nonce('0, '0);
      drain_pipeline();
   endtask

   // receiver holds off long enough for the chain to fill and stall the sender
   task automatic test_backpressure();
      int unsigned saved_pct;
      saved_pct = req_idle_pct;
      req_idle_pct = 0;
      hold_token <= hold_token + 1;
      for (int i = 0; i < 100; i++) send_nonce(rand_dword(), rand_dword());
      req_idle_pct = saved_pct;
      drain_pipeline();
   endtask

   task automatic test_random_traffic();
      for (int c = 0; c < NUM_CHUNKS; c++) begin
         if (c == 5) begin
            req_idle_pct = 55;
            rsp_idle_pct = 18;
         end else if (c == 10) begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         // new key for each chunk, with the block idle
         if (c == 3) begin
            load_key('0, '0, '0, '0);
         end else if (c == 7) begin
            load_key('1, '1, '1, '1);
         end else if (c % 2 == 0) begin
            write_key_reg(csr_index_type'($urandom_range(3)), rand_dword());
            key_settings++;
         end else begin
            load_key(rand_dword(), rand_dword(), rand_dword(), rand_dword());
         end
         for (int i = 0; i < CHUNK_ITEMS; i++) send_nonce(rand_dword(), rand_dword());
         drain_pipeline();
      end
   endtask

   // receiver ready, with random idling and requested long holds
   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // compare each subkey item with the oldest one logged
   always @(posedge clock) begin
      rsp_payload_type exp_sk;
      if (!reset && rsp_valid && rsp_ready) begin
         if (subkey_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected subkey item: %h", rsp_data);
         end else begin
            exp_sk = subkey_queue.pop_front();
            subkeys_checked++;
            if (rsp_data.subkey_words_0_1 !== exp_sk.subkey_words_0_1) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("subkey_words_0_1: expected %h actual %h",
                           exp_sk.subkey_words_0_1, rsp_data.subkey_words_0_1);
            end
            if (rsp_data.subkey_words_2_3 !== exp_sk.subkey_words_2_3) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("subkey_words_2_3: expected %h actual %h",
                           exp_sk.subkey_words_2_3, rsp_data.subkey_words_2_3);
            end
            if (rsp_data.subkey_words_4_5 !== exp_sk.subkey_words_4_5) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("subkey_words_4_5: expected %h actual %h",
                           exp_sk.subkey_words_4_5, rsp_data.subkey_words_4_5);
            end
            if (rsp_data.subkey_words_6_7 !== exp_sk.subkey_words_6_7) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("subkey_words_6_7: expected %h actual %h",
                           exp_sk.subkey_words_6_7, rsp_data.subkey_words_6_7);
            end
         end
      end
   end

   // watchdog on cycles with no handshake on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", stall_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_key_extremes();
      test_walking_bits();
      test_backpressure();
      test_random_traffic();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d nonces under %0d key settings, %0d subkeys compared",
               nonces_sent, key_settings, subkeys_checked);
      $display("idle mixes on both sides, a long receiver hold and drained pauses included");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
